[design/apu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Availability pattern update package
// Shared state type and register addresses for the pattern learner.
// ----------------------------------------------------------------------------
package apu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam logic ADDR_MAX_DEV    = 1'b0;
    localparam logic ADDR_CHANGE_THR = 1'b1;

endpackage
`default_nettype wire

[design/apu_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Availability pattern update remainder unit
// Restoring bit-serial remainder of two 32-bit values, one bit per cycle.
// ----------------------------------------------------------------------------
module apu_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      remainder
);

    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;

    always_comb
    begin
        shifted    = {rem_reg[31:0], quo_reg[31]};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (shifted >= {1'b0, dsr_reg})
                rem_next = shifted - {1'b0, dsr_reg};
            else
                rem_next = shifted;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[31:0];

endmodule
`default_nettype wire

[design/availability_pattern_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Availability pattern update
// Learns a periodic contact window (period, offset, on-time) from observations.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// in        input      in_valid/ready   now_time, contact_on_time,
//                                       prior_contact_end, new_contact
// out       output     out_valid/ready  pattern_* , contacts_counted, history
// cfg       input      APB              max_deviation, change_threshold
//
// A widening or rejected item has its result presented the cycle after
// acceptance. A new-contact item runs one or two 32-bit remainders through one
// shared bit-serial divider in turn and then passes the FINISH state before its
// result is presented. Every item ends with a result held in an output
// register until taken; the next item is accepted only once the result has
// been taken. Reset clears all learned state.
// ----------------------------------------------------------------------------
module availability_pattern_update (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] now_time,
    input  wire logic [31:0] contact_on_time,
    input  wire logic [63:0] prior_contact_end,
    input  wire logic        new_contact,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             pattern_valid,
    output logic [31:0]      pattern_period,
    output logic [31:0]      pattern_offset,
    output logic [31:0]      pattern_on_time,
    output logic [31:0]      contacts_counted,
    output logic [31:0]      change_history,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    apu_pkg::state_t state_reg, state_next;

    logic [31:0] max_dev_reg, chg_thr_reg;
    logic [31:0] on_reg, period_reg, offset_reg, prev_on_reg, count_reg, hist_reg;
    logic        valid_reg;

    // Latched item and intermediate values.
    logic [31:0] start_reg, nper_reg, non_reg, in_on_reg;

    // Divider connections.
    logic        div_start, div_done;
    logic [31:0] div_a, div_b, div_rem;

    logic [31:0] n_on_w, start_w;
    logic [63:0] per64_w;
    logic        bad_w;

    // Window overlap of old and new windows, 33-bit ends.
    logic [32:0] a1, b1, lo, hi;
    logic        sig_w;

    apu_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .remainder(div_rem)
    );

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            apu_pkg::ADDR_MAX_DEV:    prdata = max_dev_reg;
            apu_pkg::ADDR_CHANGE_THR: prdata = chg_thr_reg;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dev_reg <= '0;
            chg_thr_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == apu_pkg::ADDR_MAX_DEV)
                max_dev_reg <= pwdata;
            else
                chg_thr_reg <= pwdata;
        end
    end

    // Combinational front end on the input item.
    assign n_on_w  = (on_reg > contact_on_time) ? on_reg : contact_on_time;
    assign start_w = now_time[31:0] - contact_on_time;
    assign per64_w = {32'd0, start_w} - prior_contact_end + {32'd0, prev_on_reg};
    assign bad_w   = (prior_contact_end >= {32'd0, start_w}) || (per64_w[31:0] == '0)
                     || (n_on_w > per64_w[31:0]);

    assign a1 = {1'b0, offset_reg} + {1'b0, on_reg};
    assign b1 = {1'b0, div_rem} + {1'b0, non_reg};
    assign lo = (offset_reg > div_rem) ? {1'b0, offset_reg} : {1'b0, div_rem};
    assign hi = (a1 < b1) ? a1 : b1;
    assign sig_w = valid_reg && (((hi > lo) ? hi - lo : 33'd0) < {1'b0, chg_thr_reg});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            apu_pkg::ST_IDLE:
                if (in_valid)
                begin
                    if (!new_contact || contact_on_time >= prev_on_reg || bad_w)
                        state_next = apu_pkg::ST_OUT;
                    else if (period_reg != '0 && per64_w[31:0] > period_reg)
                        state_next = apu_pkg::ST_DIV1;
                    else
                        state_next = apu_pkg::ST_DIV2;
                end
            apu_pkg::ST_DIV1:
                if (div_done)
                    state_next = apu_pkg::ST_DIV2;
            apu_pkg::ST_DIV2:
                if (div_done)
                    state_next = apu_pkg::ST_FINISH;
            apu_pkg::ST_FINISH:
                state_next = apu_pkg::ST_OUT;
            apu_pkg::ST_OUT:
                if (out_ready)
                    state_next = apu_pkg::ST_IDLE;
            default:
                state_next = apu_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready  = (state_reg == apu_pkg::ST_IDLE);
        out_valid = (state_reg == apu_pkg::ST_OUT);
        div_start = 1'b0;
        div_a     = start_reg;
        div_b     = nper_reg;
        case (state_reg)
            apu_pkg::ST_IDLE:
            begin
                div_start = (state_next == apu_pkg::ST_DIV1)
                            || (state_next == apu_pkg::ST_DIV2);
                div_b = (state_next == apu_pkg::ST_DIV1) ? period_reg : per64_w[31:0];
                div_a = (state_next == apu_pkg::ST_DIV1) ? per64_w[31:0] : start_w;
            end
            apu_pkg::ST_DIV1:
            begin
                div_start = div_done;
                div_b = (div_rem < max_dev_reg) ? period_reg : nper_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= apu_pkg::ST_IDLE;
            on_reg      <= '0;
            period_reg  <= '0;
            offset_reg  <= '0;
            prev_on_reg <= '0;
            valid_reg   <= 1'b0;
            count_reg   <= '0;
            hist_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == apu_pkg::ST_IDLE && in_valid)
            begin
                if (!new_contact || contact_on_time >= prev_on_reg)
                begin
                    prev_on_reg <= contact_on_time;
                    if (period_reg != '0 && n_on_w > period_reg)
                    begin
                        on_reg    <= '0;
                        count_reg <= '0;
                        valid_reg <= 1'b0;
                    end
                    else
                        on_reg <= n_on_w;
                end
                else if (bad_w)
                begin
                    on_reg    <= '0;
                    count_reg <= '0;
                    valid_reg <= 1'b0;
                end
            end
            if (state_reg == apu_pkg::ST_DIV2 && div_done)
            begin
                hist_reg    <= {hist_reg[30:0], sig_w};
                valid_reg   <= 1'b1;
                count_reg   <= count_reg + 32'd1;
                on_reg      <= non_reg;
                period_reg  <= nper_reg;
                offset_reg  <= div_rem;
                prev_on_reg <= in_on_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == apu_pkg::ST_IDLE && in_valid)
        begin
            start_reg <= start_w;
            nper_reg  <= per64_w[31:0];
            non_reg   <= n_on_w;
            in_on_reg <= contact_on_time;
        end
        else if (state_reg == apu_pkg::ST_DIV1 && div_done)
            nper_reg <= div_b;
    end

    assign pattern_valid    = valid_reg;
    assign pattern_period   = period_reg;
    assign pattern_offset   = offset_reg;
    assign pattern_on_time  = on_reg;
    assign contacts_counted = count_reg;
    assign change_history   = hist_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != apu_pkg::ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apu_pkg::ST_OUT) |-> !div_start)
        else $error("divider started while a result waits");
    a_period_nz: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (period_reg != '0))
        else $error("valid pattern with zero period");
`endif

endmodule
`default_nettype wire
